[rtl/sha256_stream_hasher_unit_macros.svh]
// assertion macros for the stream hasher
`ifndef SHA256_STREAM_HASHER_UNIT_MACROS_SVH
`define SHA256_STREAM_HASHER_UNIT_MACROS_SVH

// same-cycle implication
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sha_pkg.sv]
// package with types, constants and round functions of the hasher
`default_nettype none
package sha_pkg;

  localparam int unsigned ItemBits = 8;
  localparam int unsigned WordBits = 32;
  localparam int unsigned LenBits = 64;
  localparam int unsigned NumRounds = 64;
  localparam int unsigned NumHash = 8;
  localparam int unsigned BlockBits = 512;
  localparam logic [5:0] LenOffset = 6'd56;
  localparam logic [7:0] PadMarker = 8'h80;

  typedef struct packed {
    logic [ItemBits-1:0] msg_byte;
    logic                byte_present;
    logic                end_of_message;
  } item_t;

  typedef struct packed {
    logic start;
    logic reinit;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef struct packed {
    logic core_busy;
    logic pad_on;
  } back_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_OUT
  } back_state_e;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN,
    PH_DONE
  } pad_phase_e;

  localparam logic [NumHash-1:0][WordBits-1:0] HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [WordBits-1:0] RoundK [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] sm_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] sm_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage
`default_nettype wire

[rtl/sha_ifs.sv]
// handshake interfaces for the input and digest channels
`default_nettype none
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source(output valid, msg_byte, byte_present, end_of_message, input ready);
  modport sink(input valid, msg_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;
  modport source(output valid, digest_word, last_word, input ready);
  modport sink(input valid, digest_word, last_word, output ready);
endinterface
`default_nettype wire

[rtl/sha256_stream_hasher_unit.sv]
// top level of the streaming sha-256 hasher
//
// channel  dir  handshake     payload
// in_i     in   valid/ready   msg_byte, byte_present, end_of_message
// out_o    out  valid/ready   digest_word, last_word
//
// a queued byte is taken while idle; every 64th byte starts a compression in the round unit
// end of message adds padding (marker, zeros, 64-bit length) and one or two compressions
// then eight digest items, one per cycle while out_o.ready is high
// items with neither byte nor end are taken and dropped; a 4-deep queue holds the rest
// reset is asynchronous and active low; hash words return to the initial values
`default_nettype none
`include "sha256_stream_hasher_unit_macros.svh"
module sha256_stream_hasher_unit
  import sha_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  sha_in_if.sink     in_i,
  sha_out_if.source  out_o
);

  logic       q_valid;
  logic       q_pop;
  item_t      q_item;
  back_stat_t bst;

  sha_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_valid_o(q_valid),
    .q_item_o (q_item),
    .q_pop_i  (q_pop)
  );

  sha_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_item_i (q_item),
    .q_pop_o  (q_pop),
    .out_o    (out_o),
    .stat_o   (bst)
  );

  `SHA_ASSERT_IMP(a_out_idle_core, out_o.valid, !bst.core_busy, "digest while compressing")
  `SHA_ASSERT_IMP(a_out_in_pad, out_o.valid, bst.pad_on, "digest without end of message")
  `SHA_ASSERT_NXT(a_last_ends, out_o.valid && out_o.ready && out_o.last_word, !out_o.valid,
                  "digest runs past last word")

endmodule
`default_nettype wire

[rtl/sha_front.sv]
// input stage: accepts items, drops empty ones, queues the rest
`default_nettype none
module sha_front
  import sha_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  sha_in_if.sink in_i,
  output logic  q_valid_o,
  output item_t q_item_o,
  input  wire   q_pop_i
);

  item_t       mem_q [4];
  logic [1:0]  wr_ptr_q, rd_ptr_q;
  logic [2:0]  cnt_q;
  logic        push;
  logic        pop;

  assign in_i.ready = (cnt_q != 3'd4);
  assign push = in_i.valid && in_i.ready && (in_i.byte_present || in_i.end_of_message);
  assign pop = q_pop_i && (cnt_q != 3'd0);
  assign q_valid_o = (cnt_q != 3'd0);
  assign q_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{msg_byte: in_i.msg_byte, byte_present: in_i.byte_present,
                           end_of_message: in_i.end_of_message};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
      if (push && !pop) cnt_q <= cnt_q + 3'd1;
      else if (pop && !push) cnt_q <= cnt_q - 3'd1;
    end
  end

endmodule
`default_nettype wire

[rtl/sha_core.sv]
// compression unit: one round per cycle, hash words held here
`default_nettype none
module sha_core
  import sha_pkg::*;
(
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  core_ctrl_t                       ctrl_i,
  input  wire  [BlockBits-1:0]             block_i,
  output core_stat_t                       stat_o,
  output logic [NumHash-1:0][WordBits-1:0] hash_o
);

  logic [NumHash-1:0][WordBits-1:0] hash_q, v_q, v_d;
  logic [15:0][WordBits-1:0]        w_q, w_d;
  logic [5:0]                       rnd_q;
  logic                             busy_q, fin_q, done_q;
  logic [31:0]                      t1, t2, w_new;

  assign hash_o = hash_q;
  assign stat_o = '{busy: busy_q || fin_q, done: done_q};

  always_comb begin
    t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
         + RoundK[rnd_q] + w_q[0];
    t2 = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_new = sm_s1(w_q[14]) + w_q[9] + sm_s0(w_q[1]) + w_q[0];
    v_d[7] = v_q[6];
    v_d[6] = v_q[5];
    v_d[5] = v_q[4];
    v_d[4] = v_q[3] + t1;
    v_d[3] = v_q[2];
    v_d[2] = v_q[1];
    v_d[1] = v_q[0];
    v_d[0] = t1 + t2;
    for (int i = 0; i < 15; i++) w_d[i] = w_q[i+1];
    w_d[15] = w_new;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      v_q <= hash_q;
      for (int i = 0; i < 16; i++) w_q[i] <= block_i[BlockBits-1-32*i -: 32];
    end else if (busy_q) begin
      v_q <= v_d;
      w_q <= w_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= HashInit;
      rnd_q  <= '0;
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (ctrl_i.reinit) begin
        hash_q <= HashInit;
      end
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        for (int i = 0; i < NumHash; i++) hash_q[i] <= hash_q[i] + v_q[i];
        done_q <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/sha_back.sv]
// back end: block assembly, padding, compression control, digest output
`default_nettype none
module sha_back
  import sha_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       q_valid_i,
  input  item_t     q_item_i,
  output logic      q_pop_o,
  sha_out_if.source out_o,
  output back_stat_t stat_o
);

  back_state_e                      state_q, state_d;
  pad_phase_e                       ph_q, ph_d;
  logic [BlockBits-1:0]             block_q;
  logic [5:0]                       cnt_q;
  logic [LenBits-1:0]               len_q, len_d, padlen_q, padlen_d;
  logic                             pad_on_q, pad_on_d;
  logic [2:0]                       lidx_q, lidx_d, widx_q, widx_d;
  logic                             start_q, start_d;
  logic                             push;
  logic [7:0]                       push_byte;
  logic                             reinit;
  core_stat_t                       cst;
  logic [NumHash-1:0][WordBits-1:0] hash;

  sha_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i ('{start: start_q, reinit: reinit}),
    .block_i(block_q),
    .stat_o (cst),
    .hash_o (hash)
  );

  assign out_o.digest_word = hash[widx_q];
  assign out_o.last_word   = (widx_q == 3'd7);
  assign stat_o = '{core_busy: cst.busy, pad_on: pad_on_q};

  always_comb begin
    state_d   = state_q;
    ph_d      = ph_q;
    len_d     = len_q;
    padlen_d  = padlen_q;
    pad_on_d  = pad_on_q;
    lidx_d    = lidx_q;
    widx_d    = widx_q;
    start_d   = 1'b0;
    push      = 1'b0;
    push_byte = 8'h00;
    q_pop_o   = 1'b0;
    reinit    = 1'b0;
    out_o.valid = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (q_item_i.byte_present) begin
            push      = 1'b1;
            push_byte = q_item_i.msg_byte;
            len_d     = len_q + 64'd8;
          end
          if (q_item_i.end_of_message) begin
            pad_on_d = 1'b1;
            padlen_d = len_d;
            ph_d     = PH_MARK;
            lidx_d   = '0;
            state_d  = ST_PAD;
          end
          if (push && cnt_q == 6'd63) begin
            start_d = 1'b1;
            state_d = ST_COMP;
          end
        end
      end
      ST_PAD: begin
        case (ph_q)
          PH_MARK: begin
            push      = 1'b1;
            push_byte = PadMarker;
            ph_d      = PH_ZERO;
          end
          PH_ZERO: begin
            if (cnt_q == LenOffset) begin
              ph_d = PH_LEN;
            end else begin
              push = 1'b1;
            end
          end
          PH_LEN: begin
            push      = 1'b1;
            push_byte = padlen_q[LenBits-1 -: 8];
            padlen_d  = {padlen_q[LenBits-9:0], 8'h00};
            lidx_d    = lidx_q + 3'd1;
            if (lidx_q == 3'd7) ph_d = PH_DONE;
          end
          default: ;
        endcase
        if (push && cnt_q == 6'd63) begin
          start_d = 1'b1;
          state_d = ST_COMP;
        end
      end
      ST_COMP: begin
        if (cst.done) begin
          if (!pad_on_q) state_d = ST_IDLE;
          else if (ph_q == PH_DONE) state_d = ST_OUT;
          else state_d = ST_PAD;
        end
      end
      ST_OUT: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'd7) begin
            reinit   = 1'b1;
            len_d    = '0;
            pad_on_d = 1'b0;
            state_d  = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push) block_q <= {block_q[BlockBits-9:0], push_byte};
    padlen_q <= padlen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ph_q     <= PH_MARK;
      cnt_q    <= '0;
      len_q    <= '0;
      pad_on_q <= 1'b0;
      lidx_q   <= '0;
      widx_q   <= '0;
      start_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ph_q     <= ph_d;
      len_q    <= len_d;
      pad_on_q <= pad_on_d;
      lidx_q   <= lidx_d;
      widx_q   <= widx_d;
      start_q  <= start_d;
      if (push) cnt_q <= cnt_q + 6'd1;
    end
  end

endmodule
`default_nettype wire

[tb/testbench.sv]
// testbench for the streaming sha-256 hasher: directed table, random messages, digest check
`timescale 1ns / 100ps
`default_nettype none
module testbench
  import sha_pkg::*;
;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned RandItems = 249;

  typedef struct {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
    logic       has_known;
    logic [31:0] known_w0;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  sha_in_if  in_ch();
  sha_out_if out_ch();

  sha256_stream_hasher_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  // digest predictor state
  logic [31:0] hash_st [8];
  logic [7:0]  blk_buf [64];
  int unsigned blk_cnt;
  logic [63:0] msg_bits;

  logic [31:0] digest_q [$];
  logic        last_q [$];
  logic [31:0] known_q [$];
  logic        known_v_q [$];

  stim_row_t   table_rows [$];
  stim_row_t   send_q [$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          stim_done;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_blk();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
           + (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
    a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
    e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
         + RoundK[i] + w[i];
      t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endtask

  task automatic absorb_byte(input logic [7:0] v);
    blk_buf[blk_cnt] = v;
    blk_cnt++;
    if (blk_cnt == 64) begin
      compress_blk();
      blk_cnt = 0;
    end
  endtask

  task automatic hash_reinit();
    for (int i = 0; i < 8; i++) hash_st[i] = HashInit[i];
    blk_cnt = 0;
    msg_bits = '0;
  endtask

  task automatic predict_item(input stim_row_t r);
    logic [63:0] len;
    if (r.byte_present) begin
      msg_bits += 64'd8;
      absorb_byte(r.msg_byte);
    end
    if (r.end_of_message) begin
      len = msg_bits;
      absorb_byte(PadMarker);
      while (blk_cnt != LenOffset) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(len[63-8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        digest_q.push_back(hash_st[i]);
        last_q.push_back(i == 7);
        known_v_q.push_back(i == 0 && r.has_known);
        known_q.push_back(r.known_w0);
      end
      hash_reinit();
    end
  endtask

  function automatic stim_row_t mk(input logic [7:0] b, input logic p, input logic e,
                                   input logic k = 1'b0, input logic [31:0] w0 = '0);
    stim_row_t r;
    r.msg_byte = b; r.byte_present = p; r.end_of_message = e;
    r.has_known = k; r.known_w0 = w0;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sender: bursts and gaps
  initial begin
    int unsigned burst, gap;
    stim_row_t r;
    in_ch.valid <= 1'b0;
    in_ch.msg_byte <= '0;
    in_ch.byte_present <= 1'b0;
    in_ch.end_of_message <= 1'b0;
    stim_done = 1'b0;
    hash_reinit();
    // empty message, then "abc", two one-byte messages, another empty one and a two-byte one
    table_rows.push_back(mk(8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442));
    table_rows.push_back(mk(8'h61, 1'b1, 1'b0));
    table_rows.push_back(mk(8'h00, 1'b0, 1'b0));
    table_rows.push_back(mk(8'h62, 1'b1, 1'b0));
    table_rows.push_back(mk(8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf));
    table_rows.push_back(mk(8'hff, 1'b1, 1'b1));
    table_rows.push_back(mk(8'h00, 1'b1, 1'b1));
    table_rows.push_back(mk(8'h5a, 1'b0, 1'b1, 1'b1, 32'he3b0c442));
    table_rows.push_back(mk(8'haa, 1'b1, 1'b0));
    table_rows.push_back(mk(8'h55, 1'b1, 1'b0));
    table_rows.push_back(mk(8'h00, 1'b0, 1'b1));
    foreach (table_rows[i]) send_q.push_back(table_rows[i]);
    // random messages: short lengths and lengths around the one- and two-block padding edges
    while (send_q.size() < table_rows.size() + RandItems) begin
      int unsigned len;
      int unsigned room;
      case ($urandom_range(0, 3))
        0: len = $urandom_range(0, 10);
        1: len = $urandom_range(54, 57);
        2: len = $urandom_range(62, 66);
        default: len = $urandom_range(110, 130);
      endcase
      room = table_rows.size() + RandItems - send_q.size();
      if (len >= room) len = room - 1;
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_q.push_back(mk(8'($urandom_range(0, 255)), 1'b0, 1'b0));
        send_q.push_back(mk(8'($urandom_range(0, 255)), 1'b1, 1'b0));
      end
      send_q.push_back(mk(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1));
    end
    @(posedge clk_i iff rst_ni);
    while (send_q.size() > 0) begin
      burst = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      while (burst > 0 && send_q.size() > 0) begin
        r = send_q[0];
        in_ch.valid <= 1'b1;
        in_ch.msg_byte <= r.msg_byte;
        in_ch.byte_present <= r.byte_present;
        in_ch.end_of_message <= r.end_of_message;
        @(posedge clk_i iff in_ch.ready);
        predict_item(r);
        void'(send_q.pop_front());
        burst--;
      end
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver stall pattern with one long hold-off
  initial begin
    int unsigned cyc;
    cyc = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == 400) begin
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge clk_i);
      end else if ((cyc / 50) % 3 == 0)
        out_ch.ready <= 1'b1;
      else
        out_ch.ready <= ($urandom_range(0, 2) != 0);
    end
  end

  // digest checker and watchdog
  initial begin
    logic [31:0] w;
    logic        l, kv;
    logic [31:0] kw;
    mismatches = 0;
    idle_cycles = 0;
    @(posedge clk_i iff rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (digest_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected digest item %h", out_ch.digest_word);
        end else begin
          w = digest_q.pop_front();
          l = last_q.pop_front();
          kv = known_v_q.pop_front();
          kw = known_q.pop_front();
          if (out_ch.digest_word !== w || out_ch.last_word !== l ||
              (kv && out_ch.digest_word !== kw)) begin
            mismatches++;
            if (mismatches <= 10)
              $display("digest mismatch: exp %h/%0b act %h/%0b", w, l,
                       out_ch.digest_word, out_ch.last_word);
          end
        end
      end
      if (stim_done && digest_q.size() == 0) begin
        repeat (200) @(posedge clk_i);
        if (mismatches == 0 && digest_q.size() == 0 && !out_ch.valid)
          $display("Regression PASS");
        else
          $display("Regression FAIL");
        $finish;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire

[sha256_stream_hasher_unit.f]
+incdir+rtl
rtl/sha_pkg.sv
rtl/sha_ifs.sv
rtl/sha_front.sv
rtl/sha_core.sv
rtl/sha_back.sv
rtl/sha256_stream_hasher_unit.sv
tb/testbench.sv
